// ===== rtl/quic_ih_pkg.sv =====
// Shared types and constants for the QUIC Initial header parser.
`default_nettype none

package quic_ih_pkg;

    // Largest connection ID length accepted in the header
    localparam logic [7:0] MAX_CID_LEN = 8'd20;

    // First-byte checks
    localparam int unsigned LONG_HDR_BIT = 7;
    localparam logic [1:0] PKT_TYPE_INITIAL = 2'b00;

    // Version field is four bytes
    localparam logic [7:0] VERSION_BYTES = 8'd4;

    // Fixed offset of the destination connection ID
    localparam logic [2:0] DST_CID_OFS = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        valid_res;
        logic [7:0]  ver_msb;
        logic [2:0]  dst_cid_ofs;
        logic [4:0]  dst_cid_len;
        logic [4:0]  src_cid_ofs;
        logic [4:0]  src_cid_len;
        logic [5:0]  tok_ofs;
        logic [7:0]  tok_size;
        logic [15:0] payload_length;
    } res_item_t;

endpackage

`default_nettype wire

// ===== rtl/quic_initial_header_parser_unit.sv =====
// Top level of the QUIC long-header Initial packet header parser.
`default_nettype none

// Takes one datagram byte per item and walks the long header with a small
// phase machine: first byte (long-header bit set, packet type Initial), four
// version bytes (must not all be zero), DCID length and bytes, SCID length and
// bytes, a one-byte token length and the token, then two raw length bytes.
// Both ID lengths must be at most MAX_CID_LEN. Bytes past the header, or past
// a failed check, are ignored. Exactly one result item leaves on
// the byte flagged last_byte; valid_res is 1 only if the whole header fit in
// the datagram and passed every check, and all other fields are zero when it
// is 0. The parser then returns to its reset state for the next datagram.
// Rate: one byte per clock unless stalled. The phase update and the result fields
// are a single level of logic feeding the phase registers and one result
// register, so a new byte is taken every cycle; the byte stall is raised only
// while a finished result sits in the result register and the downstream side
// is stalling it. The result is registered and appears in the cycle after the last byte.
module quic_initial_header_parser_unit
    import quic_ih_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    output      logic      byte_stall,
    input  wire in_item_t  byte_item,
    output      logic      res_valid,
    input  wire logic      res_stall,
    output      res_item_t res_item
);

    // Header walk phases
    localparam logic [3:0] PH_FIRST = 4'd0;
    localparam logic [3:0] PH_VER   = 4'd1;
    localparam logic [3:0] PH_DCIL  = 4'd2;
    localparam logic [3:0] PH_DCID  = 4'd3;
    localparam logic [3:0] PH_SCIL  = 4'd4;
    localparam logic [3:0] PH_SCID  = 4'd5;
    localparam logic [3:0] PH_TOKL  = 4'd6;
    localparam logic [3:0] PH_TOK   = 4'd7;
    localparam logic [3:0] PH_LENH  = 4'd8;
    localparam logic [3:0] PH_LENL  = 4'd9;
    localparam logic [3:0] PH_DONE  = 4'd10;

    logic [3:0] phase_reg,     phase_next;
    logic [7:0] skip_reg,      skip_next;
    logic       failed_reg,    failed_next;
    logic       ver_nz_reg,    ver_nz_next;
    logic [7:0] ver_first_reg, ver_first_next;
    logic [4:0] dcid_len_reg,  dcid_len_next;
    logic [4:0] scid_len_reg,  scid_len_next;
    logic [7:0] tok_len_reg,   tok_len_next;
    logic [7:0] len_hi_reg,    len_hi_next;
    logic [7:0] len_lo_reg,    len_lo_next;

    logic       res_valid_reg;
    res_item_t  res_item_reg, res_item_next;

    logic       accept;
    logic [7:0] b;
    logic [7:0] skip_dec;
    logic       hdr_ok;

    // Only a held, stalled result blocks the input side
    assign byte_stall = res_valid_reg & res_stall;
    assign accept     = byte_valid & ~byte_stall;
    assign b          = byte_item.data_byte;
    assign skip_dec   = (skip_reg != 8'd0) ? skip_reg - 8'd1 : skip_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        skip_next      = skip_reg;
        failed_next    = failed_reg;
        ver_nz_next    = ver_nz_reg;
        ver_first_next = ver_first_reg;
        dcid_len_next  = dcid_len_reg;
        scid_len_next  = scid_len_reg;
        tok_len_next   = tok_len_reg;
        len_hi_next    = len_hi_reg;
        len_lo_next    = len_lo_reg;

        case (phase_reg)
            PH_FIRST:
            begin
                if (!b[LONG_HDR_BIT] || (b[5:4] != PKT_TYPE_INITIAL))
                begin
                    failed_next = 1'b1;
                    phase_next  = PH_DONE;
                end
                else
                begin
                    phase_next = PH_VER;
                    skip_next  = VERSION_BYTES;
                end
            end
            PH_VER:
            begin
                if (skip_reg == VERSION_BYTES)
                    ver_first_next = b;
                if (b != 8'd0)
                    ver_nz_next = 1'b1;
                skip_next = skip_dec;
                if (skip_dec == 8'd0)
                begin
                    if (!ver_nz_next)
                    begin
                        failed_next = 1'b1;
                        phase_next  = PH_DONE;
                    end
                    else
                        phase_next = PH_DCIL;
                end
            end
            PH_DCIL:
            begin
                if (b > MAX_CID_LEN)
                begin
                    failed_next = 1'b1;
                    phase_next  = PH_DONE;
                end
                else
                begin
                    dcid_len_next = b[4:0];
                    skip_next     = b;
                    phase_next    = (b == 8'd0) ? PH_SCIL : PH_DCID;
                end
            end
            PH_DCID:
            begin
                skip_next = skip_dec;
                if (skip_dec == 8'd0)
                    phase_next = PH_SCIL;
            end
            PH_SCIL:
            begin
                if (b > MAX_CID_LEN)
                begin
                    failed_next = 1'b1;
                    phase_next  = PH_DONE;
                end
                else
                begin
                    scid_len_next = b[4:0];
                    skip_next     = b;
                    phase_next    = (b == 8'd0) ? PH_TOKL : PH_SCID;
                end
            end
            PH_SCID:
            begin
                skip_next = skip_dec;
                if (skip_dec == 8'd0)
                    phase_next = PH_TOKL;
            end
            PH_TOKL:
            begin
                tok_len_next = b;
                skip_next    = b;
                phase_next   = (b == 8'd0) ? PH_LENH : PH_TOK;
            end
            PH_TOK:
            begin
                skip_next = skip_dec;
                if (skip_dec == 8'd0)
                    phase_next = PH_LENH;
            end
            PH_LENH:
            begin
                len_hi_next = b;
                phase_next  = PH_LENL;
            end
            PH_LENL:
            begin
                len_lo_next = b;
                phase_next  = PH_DONE;
            end
            default:
            begin
                // header finished or abandoned: ignore the rest
            end
        endcase
    end

    // Header complete: reached the end of the walk without a failed check
    assign hdr_ok = (phase_next == PH_DONE) & ~failed_next;

    always_comb
    begin
        res_item_next = '0;
        if (hdr_ok)
        begin
            res_item_next.valid_res      = 1'b1;
            res_item_next.ver_msb        = ver_first_next;
            res_item_next.dst_cid_ofs    = DST_CID_OFS;
            res_item_next.dst_cid_len    = dcid_len_next;
            res_item_next.src_cid_ofs    = 5'd7 + dcid_len_next;
            res_item_next.src_cid_len    = scid_len_next;
            res_item_next.tok_ofs        = 6'd8 + {1'b0, dcid_len_next}
                                                + {1'b0, scid_len_next};
            res_item_next.tok_size       = tok_len_next;
            res_item_next.payload_length = {len_hi_next, len_lo_next};
        end
    end

    // Parser state; the last byte of a datagram returns it to reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            skip_reg      <= '0;
            failed_reg    <= 1'b0;
            ver_nz_reg    <= 1'b0;
            ver_first_reg <= '0;
            dcid_len_reg  <= '0;
            scid_len_reg  <= '0;
            tok_len_reg   <= '0;
            len_hi_reg    <= '0;
            len_lo_reg    <= '0;
        end
        else if (accept)
        begin
            if (byte_item.last_byte)
            begin
                phase_reg     <= PH_FIRST;
                skip_reg      <= '0;
                failed_reg    <= 1'b0;
                ver_nz_reg    <= 1'b0;
                ver_first_reg <= '0;
                dcid_len_reg  <= '0;
                scid_len_reg  <= '0;
                tok_len_reg   <= '0;
                len_hi_reg    <= '0;
                len_lo_reg    <= '0;
            end
            else
            begin
                phase_reg     <= phase_next;
                skip_reg      <= skip_next;
                failed_reg    <= failed_next;
                ver_nz_reg    <= ver_nz_next;
                ver_first_reg <= ver_first_next;
                dcid_len_reg  <= dcid_len_next;
                scid_len_reg  <= scid_len_next;
                tok_len_reg   <= tok_len_next;
                len_hi_reg    <= len_hi_next;
                len_lo_reg    <= len_lo_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept && byte_item.last_byte)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && byte_item.last_byte)
            res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

`default_nettype wire

// ===== rtl/quic_ih_checker.sv =====
// Port-level checker for the QUIC Initial header parser, with its bind.
`default_nettype none

module quic_ih_checker
    import quic_ih_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      byte_valid,
    input wire logic      byte_stall,
    input wire in_item_t  byte_item,
    input wire logic      res_valid,
    input wire logic      res_stall,
    input wire res_item_t res_item
);

    // A stalled result stays and holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("result dropped or changed while stalled");

    // Input side is blocked only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> res_valid && res_stall)
        else $error("byte stall without a blocked result");

    // A new result follows an accepted last byte
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !$past(res_valid && res_stall)
            |-> $past(byte_valid && !byte_stall && byte_item.last_byte))
        else $error("result without a closing byte");

    // Rejected headers carry zero version, ID lengths, token fields and payload length
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.valid_res
            |-> res_item.ver_msb == 8'd0 && res_item.dst_cid_len == 5'd0
                && res_item.src_cid_len == 5'd0 && res_item.tok_size == 8'd0
                && res_item.payload_length == 16'd0 && res_item.tok_ofs == 6'd0)
        else $error("rejected header with nonzero fields");

    // Accepted headers have consistent offsets and bounded ID lengths
    a_accept_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.valid_res
            |-> res_item.dst_cid_ofs == DST_CID_OFS
                && res_item.src_cid_ofs == 5'(5'd7 + res_item.dst_cid_len)
                && {3'b000, res_item.dst_cid_len} <= MAX_CID_LEN
                && {3'b000, res_item.src_cid_len} <= MAX_CID_LEN)
        else $error("inconsistent accepted header fields");

endmodule

bind quic_initial_header_parser_unit quic_ih_checker u_quic_ih_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
);

`default_nettype wire
